// ===== hdl/chained_hash_set_defines.svh =====
// assertion macros for the chained hash set
// used by the top level
`ifndef CHAINED_HASH_SET_DEFINES_SVH
`define CHAINED_HASH_SET_DEFINES_SVH
// implication checked on every clock edge outside reset
`define CHS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define CHS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/chs_pkg.sv =====
// shared types and constants of the chained hash set
// no dependencies
package chs_pkg;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;
  localparam logic       OP_INSERT  = 1'b0;
  localparam logic       OP_LOOKUP  = 1'b1;
  localparam int unsigned KEY_W      = 256;
endpackage

// ===== hdl/chs_modred.sv =====
// reduction of the 32-bit hash modulo the bucket count, one bit per cycle
// depends on nothing but its ports
module chs_modred (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] hash_value,
  input  logic [8:0]  divisor,
  output logic        done,
  output logic [8:0]  remainder
);
  logic [31:0] shreg;
  logic [9:0]  rem;
  logic [5:0]  cnt;
  logic        run;
  logic [9:0]  trial;
  logic [9:0]  rem_next;

  always_comb begin
    trial = {rem[8:0], shreg[31]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = trial - {1'b0, divisor};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && !go && (cnt == 6'd31);
      if (go) begin
        run   <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        shreg <= hash_value;
      end else if (run) begin
        rem   <= rem_next;
        shreg <= {shreg[30:0], 1'b0};
        cnt   <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          run <= 1'b0;
        end
      end
    end
  end

  assign remainder = rem[8:0];
endmodule

// ===== hdl/chained_hash_set.sv =====
// top level of the chained hash set: control, head, link and key memories
// depends on chs_pkg, chs_modred and chained_hash_set_defines.svh
//
// usage: raise start with opcode, hash_value and key_word0..3 while busy is
// low; the item is taken at that edge and busy rises. the block reduces the
// hash modulo bucket_count one bit a cycle in the serial divider, then hands
// over the bucket, reads the bucket head (a synchronous read, then a check of
// its valid bit), then walks the chain node by node (one synchronous read of
// the key and link memories, one compare). the result appears on status,
// entry_index and word_count for one cycle marked by done, and busy falls in
// the same cycle, so the next item can be taken at the edge that ends it.
// the receiver cannot stall, so results are never held. the user must write
// bucket_count by cfg_we/cfg_data only while idle; the block does not enforce
// it. 0 counts as one bucket and values above BUCKETS saturate. reset empties
// the set through per-bucket valid bits at once and sets bucket_count to 256.
`include "chained_hash_set_defines.svh"
module chained_hash_set #(
  parameter int BUCKETS = 256,
  parameter int NODES   = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [31:0] hash_value,
  input  logic [63:0] key_word0,
  input  logic [63:0] key_word1,
  input  logic [63:0] key_word2,
  input  logic [63:0] key_word3,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [9:0]  entry_index,
  output logic [10:0] word_count
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MOD  = 7'b0000010, S_HEAD = 7'b0000100,
    S_HCHK = 7'b0001000, S_READ = 7'b0010000, S_CMP  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  logic [8:0] bcount;
  logic op;
  logic [chs_pkg::KEY_W-1:0] key;
  logic [BW-1:0] bucket;
  logic [NW-1:0] node, last;
  logic walked;
  logic [CW-1:0] used;
  logic md_go, md_done;
  logic [8:0] md_rem;
  logic [8:0] divisor;

  logic [BUCKETS-1:0] head_valid;
  logic [NW-1:0] head_mem [BUCKETS];
  logic [NW-1:0] head_rd;
  logic [NW:0] next_mem [NODES];
  logic [NW:0] next_rd;
  logic [chs_pkg::KEY_W-1:0] key_mem [NODES];
  logic [chs_pkg::KEY_W-1:0] key_rd;
  logic [NW-1:0] rd_addr;

  always_comb begin
    if (bcount == 9'd0) begin
      divisor = 9'd1;
    end else if ({23'd0, bcount} > BUCKETS) begin
      divisor = 9'(BUCKETS);
    end else begin
      divisor = bcount;
    end
  end

  chs_modred u_modred (
    .clk(clk), .rst(rst), .go(md_go), .hash_value(hash_value), .divisor(divisor),
    .done(md_done), .remainder(md_rem)
  );

  assign busy  = (state != S_IDLE);
  assign md_go = (state == S_IDLE) && start;
  assign rd_addr = (state == S_HCHK) ? head_rd : node;

  always_ff @(posedge clk) begin
    head_rd <= head_mem[bucket];
    next_rd <= next_mem[rd_addr];
    key_rd  <= key_mem[rd_addr];
  end

  logic found_hit;
  assign found_hit = (key_rd == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bcount     <= 9'd256;
      head_valid <= '0;
      used       <= '0;
      done       <= 1'b0;
    end else begin
      if (cfg_we) begin
        bcount <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            op    <= opcode;
            key   <= {key_word3, key_word2, key_word1, key_word0};
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (md_done) begin
            bucket <= md_rem[BW-1:0];
            walked <= 1'b0;
            state  <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_HCHK;
        end
        S_HCHK: begin
          if (head_valid[bucket]) begin
            node  <= head_rd;
            state <= S_CMP;
          end else begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (found_hit) begin
            status      <= (op == chs_pkg::OP_INSERT) ? chs_pkg::ST_PRESENT
                                                      : chs_pkg::ST_OK;
            entry_index <= 10'(node);
            word_count  <= 11'(used);
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            walked <= 1'b1;
            last   <= node;
            if (next_rd[NW]) begin
              node  <= next_rd[NW-1:0];
              state <= S_READ;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (op == chs_pkg::OP_LOOKUP) begin
            status      <= chs_pkg::ST_MISSING;
            entry_index <= '0;
            word_count  <= 11'(used);
          end else if (used >= CW'(NODES)) begin
            status      <= chs_pkg::ST_FULL;
            entry_index <= '0;
            word_count  <= 11'(used);
          end else begin
            status      <= chs_pkg::ST_OK;
            entry_index <= 10'(used);
            word_count  <= 11'(used + CW'(1));
            used        <= used + CW'(1);
            if (!walked) begin
              head_valid[bucket] <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // memory writes on allocation of a fresh node
  logic alloc;
  assign alloc = !rst && (state == S_DONE) && (op == chs_pkg::OP_INSERT)
                 && (used < CW'(NODES));

  // the next free node's link is cleared early so it reads as end of chain
  logic clear_link;
  assign clear_link = !rst && (state == S_HEAD) && (used < CW'(NODES));

  logic link_we;
  logic [NW-1:0] link_addr;
  logic [NW:0] link_data;
  assign link_we   = (alloc && walked) || clear_link;
  assign link_addr = clear_link ? used[NW-1:0] : last;
  assign link_data = clear_link ? '0 : {1'b1, used[NW-1:0]};

  always_ff @(posedge clk) begin
    if (alloc) begin
      key_mem[used[NW-1:0]] <= key;
      if (!walked) begin
        head_mem[bucket] <= used[NW-1:0];
      end
    end
    if (link_we) begin
      next_mem[link_addr] <= link_data;
    end
  end

  `CHS_ASSERT_IMP(a_count_bound, 1'b1, used <= CW'(NODES))
  `CHS_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `CHS_ASSERT_NXT(a_done_idle, done, !done)
  `CHS_ASSERT_IMP(a_done_state, done, state == S_IDLE)
endmodule

// ===== tb/tb_chained_hash_set.sv =====
// self-checking testbench for the chained hash set
// depends on chs_pkg and the chained_hash_set top level
`timescale 1ns / 1ps

typedef struct {
  logic [1:0]  status;
  logic [9:0]  entry_index;
  logic [10:0] word_count;
} set_reply_t;

class hash_set_board;
  int unsigned buckets_in_use;
  bit          head_ok[256];
  int unsigned head_node[256];
  bit          link_ok[1024];
  int unsigned link_node[1024];
  logic [255:0] stored_key[1024];
  int unsigned used;
  set_reply_t  pending[$];
  int          errors;

  function void clear();
    buckets_in_use = 256;
    used = 0;
    errors = 0;
    pending.delete();
    foreach (head_ok[i]) head_ok[i] = 0;
    foreach (link_ok[i]) link_ok[i] = 0;
  endfunction

  function void set_buckets(logic [8:0] v);
    buckets_in_use = v;
  endfunction

  // walk the chain like the block does and queue the reply
  function void note_item(logic op, logic [31:0] h, logic [255:0] k);
    set_reply_t r;
    int unsigned cnt, bkt, nd, last, steps;
    bit have;
    cnt = buckets_in_use;
    if (cnt == 0) cnt = 1;
    if (cnt > 256) cnt = 256;
    bkt = h % cnt;
    have = head_ok[bkt];
    nd = head_node[bkt];
    last = 0;
    steps = 0;
    while (have) begin
      if (stored_key[nd] === k) begin
        r.status = (op == chs_pkg::OP_INSERT) ? chs_pkg::ST_PRESENT : chs_pkg::ST_OK;
        r.entry_index = nd[9:0];
        r.word_count = used[10:0];
        pending.push_back(r);
        return;
      end
      last = nd;
      have = link_ok[nd];
      nd = link_node[nd];
      steps++;
    end
    r.entry_index = '0;
    if (op == chs_pkg::OP_LOOKUP) r.status = chs_pkg::ST_MISSING;
    else if (used >= 1024) r.status = chs_pkg::ST_FULL;
    else begin
      stored_key[used] = k;
      link_ok[used] = 0;
      if (steps > 0) begin
        link_ok[last] = 1;
        link_node[last] = used;
      end else begin
        head_ok[bkt] = 1;
        head_node[bkt] = used;
      end
      r.status = chs_pkg::ST_OK;
      r.entry_index = used[9:0];
      used++;
    end
    r.word_count = used[10:0];
    pending.push_back(r);
  endfunction

  task check_reply(set_reply_t got);
    set_reply_t want;
    if (pending.size() == 0) begin
      report_error("reply with nothing outstanding");
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status)
      report_error($sformatf("status %0d want %0d", got.status, want.status));
    if (got.entry_index !== want.entry_index)
      report_error($sformatf("entry_index %0d want %0d", got.entry_index,
                             want.entry_index));
    if (got.word_count !== want.word_count)
      report_error($sformatf("word_count %0d want %0d", got.word_count,
                             want.word_count));
  endtask

  task report_error(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask
endclass

module tb_chained_hash_set;
  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic        opcode = 0;
  logic [31:0] hash_value = '0;
  logic [63:0] key_word0 = '0, key_word1 = '0, key_word2 = '0, key_word3 = '0;
  logic        cfg_we = 0;
  logic [8:0]  cfg_data = '0;
  logic        done;
  logic [1:0]  status;
  logic [9:0]  entry_index;
  logic [10:0] word_count;

  hash_set_board board;
  logic [255:0] known_keys[$];
  logic [31:0]  known_hash[$];
  int burst_left;

  chained_hash_set u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .hash_value(hash_value), .key_word0(key_word0), .key_word1(key_word1),
    .key_word2(key_word2), .key_word3(key_word3), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .done(done), .status(status),
    .entry_index(entry_index), .word_count(word_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    set_reply_t got;
    if (!rst && done) begin
      got.status = status;
      got.entry_index = entry_index;
      got.word_count = word_count;
      board.check_reply(got);
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // hold start high until the block takes the item
  task automatic send_item(logic op, logic [31:0] h, logic [255:0] k);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    opcode <= op;
    hash_value <= h;
    {key_word3, key_word2, key_word1, key_word0} <= k;
    start <= 1;
    do @(posedge clk); while (busy);
    board.note_item(op, h, k);
    @(negedge clk);
    start <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_buckets(logic [8:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    board.set_buckets(v);
  endtask

  task automatic random_item();
    logic [255:0] k;
    logic [31:0] h;
    int pick;
    pick = $urandom_range(0, 9);
    if (known_keys.size() != 0 && pick < 5) begin
      // revisit a previously sent key with its own hash
      int j;
      j = $urandom_range(0, known_keys.size() - 1);
      k = known_keys[j];
      h = known_hash[j];
      send_item(logic'($urandom_range(0, 1)), h, k);
    end else begin
      k = {rand_word(), rand_word(), rand_word(), rand_word()};
      h = (pick == 9) ? 32'hFFFF_FFFF : $urandom;
      if ($urandom_range(0, 3) != 0) begin
        known_keys.push_back(k);
        known_hash.push_back(h);
      end
      send_item(pick == 8 ? chs_pkg::OP_LOOKUP : chs_pkg::OP_INSERT, h, k);
    end
  endtask

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    board = new();
    board.clear();
    burst_left = 0;
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: extremes, duplicates, misses, same bucket chains
    send_item(chs_pkg::OP_LOOKUP, 32'h0, '0);
    send_item(chs_pkg::OP_INSERT, 32'h0, '0);
    send_item(chs_pkg::OP_INSERT, 32'h0, '0);
    send_item(chs_pkg::OP_LOOKUP, 32'h0, '0);
    send_item(chs_pkg::OP_INSERT, 32'hFFFF_FFFF, '1);
    send_item(chs_pkg::OP_INSERT, 32'h0000_0100, {255'b0, 1'b1});
    send_item(chs_pkg::OP_INSERT, 32'h0000_0200, {1'b1, 255'b0});
    send_item(chs_pkg::OP_LOOKUP, 32'h0000_0300, {1'b1, 255'b0});
    send_item(chs_pkg::OP_LOOKUP, 32'h0, {1'b1, 254'b0, 1'b1});
    send_item(chs_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '1);
    write_buckets(9'd0);
    send_item(chs_pkg::OP_LOOKUP, 32'h1234_5678, '1);
    send_item(chs_pkg::OP_INSERT, 32'h1234_5678, {4{64'h5555_AAAA_5555_AAAA}});
    write_buckets(9'h1FF);
    send_item(chs_pkg::OP_LOOKUP, 32'h1234_5678, {4{64'h5555_AAAA_5555_AAAA}});
    write_buckets(9'd1);
    send_item(chs_pkg::OP_LOOKUP, 32'h7, {4{64'h5555_AAAA_5555_AAAA}});
    write_buckets(9'd256);
    drain();

    for (int n = 0; n < 600; n++) begin
      if (n == 150) write_buckets(9'd3);
      if (n == 300) write_buckets(9'd97);
      if (n == 450) write_buckets(9'd256);
      random_item();
    end
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/chs_pkg.sv
hdl/chs_modred.sv
hdl/chained_hash_set.sv
tb/tb_chained_hash_set.sv
